[hw/rtl/tsri_pkg.sv]
// ----------------------------------------------------------------------------
// tsri_pkg
// Shared types and constants of the timestamped receive inbox.
// ----------------------------------------------------------------------------
package tsri_pkg;

  localparam int DEF_INBOX_DEPTH = 256;
  localparam int DEF_TIME_BITS   = 48;

  localparam int OP_W    = 3;
  localparam int TICK_W  = 16;
  localparam int STAMP_W = 48;
  localparam int BYTE_W  = 8;

  // cells examined per cycle by the due-count scan
  localparam int SCAN_GRP = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE = 3'd0,
    OP_PUSH    = 3'd1,
    OP_TAKE    = 3'd2,
    OP_READ    = 3'd3,
    OP_FLUSH   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // per-cell command from the sequencer
  typedef struct packed {
    logic shift;  // take the neighbor's entry
    logic load;   // take the pushed entry
  } cell_cmd_t;

endpackage

[hw/rtl/tsri_cell.sv]
// ----------------------------------------------------------------------------
// tsri_cell
// One inbox slot: holds a byte and its stamp, shifts toward the front.
// ----------------------------------------------------------------------------
module tsri_cell #(
  parameter int TIME_BITS = tsri_pkg::DEF_TIME_BITS,
  parameter int CNT_W     = 9,
  parameter int IDX       = 0
) (
  input  logic                      clk,
  input  tsri_pkg::cell_cmd_t       cmd,
  input  logic [tsri_pkg::BYTE_W-1:0] nb_byte,
  input  logic [TIME_BITS-1:0]      nb_stamp,
  input  logic [tsri_pkg::BYTE_W-1:0] in_byte,
  input  logic [TIME_BITS-1:0]      in_stamp,
  input  logic [TIME_BITS-1:0]      clock_now,
  input  logic [CNT_W-1:0]          count,
  output logic [tsri_pkg::BYTE_W-1:0] byte_q,
  output logic [TIME_BITS-1:0]      stamp_q,
  output logic                      due
);

  logic [tsri_pkg::BYTE_W-1:0] byte_r;
  logic [TIME_BITS-1:0]        stamp_r;

  // load wins over shift: a push into a full inbox shifts and fills the tail
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r  <= in_byte;
      stamp_r <= in_stamp;
    end else if (cmd.shift) begin
      byte_r  <= nb_byte;
      stamp_r <= nb_stamp;
    end
  end

  assign byte_q  = byte_r;
  assign stamp_q = stamp_r;
  assign due     = (CNT_W'(IDX) < count) && (stamp_r <= clock_now);

endmodule

[hw/rtl/tsri_scan.sv]
// ----------------------------------------------------------------------------
// tsri_scan
// Walks the cell row one group a cycle: counts leading due cells and picks
// the byte at the raised index.
// ----------------------------------------------------------------------------
module tsri_scan #(
  parameter int DEPTH = tsri_pkg::DEF_INBOX_DEPTH,
  parameter int CNT_W = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DEPTH-1:0]            due_vec,
  input  logic [tsri_pkg::BYTE_W-1:0] byte_vec [DEPTH],
  input  logic [CNT_W-1:0]            raised,
  output logic                        done,
  output logic [CNT_W-1:0]            due_cnt,
  output logic [tsri_pkg::BYTE_W-1:0] pick
);

  localparam int GRP    = tsri_pkg::SCAN_GRP;
  localparam int GRP_LG = $clog2(GRP);
  localparam int LEAD_W = $clog2(GRP + 1);
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
  localparam int GW     = (NGRP > 1) ? $clog2(NGRP) : 1;

  logic [GRP-1:0]              due_grp  [NGRP];
  logic [tsri_pkg::BYTE_W-1:0] byte_grp [NGRP][GRP];

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic                        run_r, run_nxt;
  logic [GW-1:0]               grp_r, grp_nxt;
  logic [CNT_W-1:0]            acc_r, acc_nxt;
  logic [tsri_pkg::BYTE_W-1:0] pick_r, pick_nxt;

  logic [LEAD_W-1:0]           lead;
  logic [CNT_W-1:0]            rgrp;
  logic [GRP_LG-1:0]           rlo;

  function automatic logic [LEAD_W-1:0] lead_ones(input logic [GRP-1:0] b);
    logic [LEAD_W-1:0] n;
    n = LEAD_W'(GRP);
    for (int i = GRP - 1; i >= 0; i--) begin
      if (!b[i]) n = LEAD_W'(i);
    end
    return n;
  endfunction

  // pad the row to whole groups with cells that are never due
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          due_grp[g][k]  = due_vec[g * GRP + k];
          byte_grp[g][k] = byte_vec[g * GRP + k];
        end else begin
          due_grp[g][k]  = 1'b0;
          byte_grp[g][k] = '0;
        end
      end
    end
  end

  assign lead = lead_ones(due_grp[grp_r]);
  assign rgrp = raised >> GRP_LG;
  assign rlo  = GRP_LG'(raised);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    run_nxt  = run_r;
    grp_nxt  = grp_r;
    acc_nxt  = acc_r;
    pick_nxt = pick_r;
    if (start) begin
      busy_nxt = 1'b1;
      run_nxt  = 1'b1;
      grp_nxt  = '0;
      acc_nxt  = '0;
      pick_nxt = '0;
    end else if (busy_r) begin
      if (run_r) begin
        acc_nxt = acc_r + CNT_W'(lead);
        if (lead != LEAD_W'(GRP)) run_nxt = 1'b0;
      end
      if (CNT_W'(grp_r) == rgrp) pick_nxt = byte_grp[grp_r][rlo];
      if (grp_r == GW'(NGRP - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        grp_nxt = grp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    run_r  <= run_nxt;
    grp_r  <= grp_nxt;
    acc_r  <= acc_nxt;
    pick_r <= pick_nxt;
  end

  assign done    = done_r;
  assign due_cnt = acc_r;
  assign pick    = pick_r;

endmodule

[hw/rtl/timestamped_receive_inbox_core.sv]
// ----------------------------------------------------------------------------
// timestamped_receive_inbox_core
// Receive inbox of time-stamped bytes held in a shifting row of cells.
// ----------------------------------------------------------------------------
// An accepted request runs the apply step, then the due-count scan over
//   NGRP = ceil(INBOX_DEPTH / 32) groups of cells, 32 cells a cycle, then
//   the finish step, which loads the result register. A new request is
//   accepted only in the idle state.
// Reset: rst_n low clears link, clock, counts and handshake state; cell
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module timestamped_receive_inbox_core #(
  parameter int INBOX_DEPTH = tsri_pkg::DEF_INBOX_DEPTH,
  parameter int TIME_BITS   = tsri_pkg::DEF_TIME_BITS,
  localparam int CNT_W      = $clog2(INBOX_DEPTH + 1),
  localparam int OUT_BITS   = 19 + 3 * CNT_W,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration: link_enabled
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_data,
  // request channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // in_tdata, low bit up: tick_count[15:0], stamp[63:16], byte_in[71:64]
  input  logic [71:0]              in_tdata,
  // in_tuser: opcode[2:0]
  input  logic [tsri_pkg::OP_W-1:0] in_tuser,
  // result channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // out_tdata, low bit up: taken, taken_byte, front_ready, front_byte,
  //   due_count, held_count, raised_count, dropped, zero fill
  output logic [OUT_W-1:0]         out_tdata
);

  localparam int BW = tsri_pkg::BYTE_W;

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  tsri_pkg::state_t state_r, state_nxt;

  logic                 link_r, link_nxt;
  logic [TIME_BITS-1:0] clock_r, clock_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     raised_r, raised_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  // request held for the duration of its work
  tsri_pkg::op_t              op_r;
  logic [tsri_pkg::TICK_W-1:0]  ticks_r;
  logic [tsri_pkg::STAMP_W-1:0] stamp_r;
  logic [BW-1:0]                byte_r;

  // partial result from the apply step
  logic          taken_r, taken_nxt;
  logic [BW-1:0] tbyte_r, tbyte_nxt;
  logic          dropped_r, dropped_nxt;

  // sequencer strobes
  logic in_accept;
  logic cfg_accept;
  logic apply_en;
  logic scan_start;
  logic finish_en;

  // cell row
  tsri_pkg::cell_cmd_t  cmd       [INBOX_DEPTH];
  logic [BW-1:0]        cell_byte [INBOX_DEPTH];
  logic [TIME_BITS-1:0] cell_stamp[INBOX_DEPTH];
  logic [INBOX_DEPTH-1:0] due_vec;

  logic                 shift_all;
  logic                 push_load;
  logic [CNT_W-1:0]     widx;
  logic [TIME_BITS-1:0] push_stamp;

  // scan results
  logic             scan_done;
  logic [CNT_W-1:0] scan_due;
  logic [BW-1:0]    scan_pick;

  // finish-step values
  logic             take_ok;
  logic [CNT_W-1:0] due_fin;
  logic             fready;
  logic [BW-1:0]    fbyte;
  logic [TIME_BITS:0] csum;
  logic             full;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign in_accept  = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsri_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = tsri_pkg::ST_APPLY;
      end
      tsri_pkg::ST_APPLY: begin
        state_nxt = tsri_pkg::ST_SCAN;
      end
      tsri_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = tsri_pkg::ST_FINISH;
      end
      tsri_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) state_nxt = tsri_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tsri_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: strobes
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready  = 1'b0;
    apply_en   = 1'b0;
    scan_start = 1'b0;
    finish_en  = 1'b0;
    case (state_r)
      tsri_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      tsri_pkg::ST_APPLY: begin
        apply_en   = 1'b1;
        scan_start = 1'b1;
      end
      tsri_pkg::ST_SCAN: begin
      end
      tsri_pkg::ST_FINISH: begin
        // hold the result until the output register is free
        finish_en = !out_valid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // apply step: clock, push, read, flush; finish step: arrived take and result
  // --------------------------------------------------------------------------
  assign csum       = {1'b0, clock_r} + (TIME_BITS + 1)'(ticks_r);
  assign full       = (count_r == CNT_W'(INBOX_DEPTH));
  assign push_stamp = TIME_BITS'(stamp_r);

  // raised entries are always due, so a take succeeds exactly when the
  // due run reaches past them
  assign take_ok = (op_r == tsri_pkg::OP_TAKE) && link_r && (scan_due > raised_r);
  assign due_fin = link_r ? scan_due : '0;
  assign fready  = (due_fin != '0);
  assign fbyte   = fready ? cell_byte[0] : '0;

  always_comb begin
    link_nxt      = link_r;
    clock_nxt     = clock_r;
    count_nxt     = count_r;
    raised_nxt    = raised_r;
    taken_nxt     = taken_r;
    tbyte_nxt     = tbyte_r;
    dropped_nxt   = dropped_r;
    shift_all     = 1'b0;
    push_load     = 1'b0;
    widx          = count_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    // a change of link state empties the inbox
    if (cfg_accept) begin
      if (cfg_data != link_r) begin
        count_nxt  = '0;
        raised_nxt = '0;
      end
      link_nxt = cfg_data;
    end

    if (apply_en) begin
      taken_nxt   = 1'b0;
      tbyte_nxt   = '0;
      dropped_nxt = 1'b0;
      case (op_r)
        tsri_pkg::OP_ADVANCE: begin
          if (link_r) begin
            // saturate at the top of the time range
            clock_nxt = csum[TIME_BITS] ? '1 : csum[TIME_BITS-1:0];
          end
        end
        tsri_pkg::OP_PUSH: begin
          if (link_r) begin
            if (full && (raised_r != '0)) begin
              // drop the oldest raised entry, fill the tail
              shift_all  = 1'b1;
              push_load  = 1'b1;
              widx       = CNT_W'(INBOX_DEPTH - 1);
              raised_nxt = raised_r - 1'b1;
            end else if (!full) begin
              push_load = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              dropped_nxt = 1'b1;
            end
          end
        end
        tsri_pkg::OP_TAKE: begin
          // resolved once the scan has run
        end
        tsri_pkg::OP_READ: begin
          if (link_r && due_vec[0]) begin
            taken_nxt = 1'b1;
            tbyte_nxt = cell_byte[0];
            shift_all = 1'b1;
            count_nxt = count_r - 1'b1;
            if (raised_r != '0) raised_nxt = raised_r - 1'b1;
          end
        end
        tsri_pkg::OP_FLUSH: begin
          count_nxt  = '0;
          raised_nxt = '0;
        end
        default: begin
          // unused opcodes change nothing
        end
      endcase
    end

    if (finish_en) begin
      if (take_ok) raised_nxt = raised_r + 1'b1;
      out_data_nxt = OUT_W'({dropped_r,
                             take_ok ? raised_r + 1'b1 : raised_r,
                             count_r,
                             due_fin,
                             fbyte,
                             fready,
                             take_ok ? scan_pick : tbyte_r,
                             taken_r | take_ok});
      out_valid_nxt = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsri_pkg::ST_IDLE;
      link_r      <= 1'b0;
      clock_r     <= '0;
      count_r     <= '0;
      raised_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      link_r      <= link_nxt;
      clock_r     <= clock_nxt;
      count_r     <= count_nxt;
      raised_r    <= raised_nxt;
      out_valid_r <= out_valid_nxt;
    end
    taken_r    <= taken_nxt;
    tbyte_r    <= tbyte_nxt;
    dropped_r  <= dropped_nxt;
    out_data_r <= out_data_nxt;
    // capture the request payload on accept
    if (in_accept) begin
      op_r    <= tsri_pkg::op_t'(in_tuser);
      ticks_r <= in_tdata[15:0];
      stamp_r <= in_tdata[63:16];
      byte_r  <= in_tdata[71:64];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // cell row: cell 0 is the front, each cell shifts from its right neighbor
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < INBOX_DEPTH; i++) begin : g_cell
    logic [BW-1:0]        nb_byte;
    logic [TIME_BITS-1:0] nb_stamp;

    if (i == INBOX_DEPTH - 1) begin : g_tail
      assign nb_byte  = '0;
      assign nb_stamp = '0;
    end else begin : g_body
      assign nb_byte  = cell_byte[i+1];
      assign nb_stamp = cell_stamp[i+1];
    end

    assign cmd[i].shift = shift_all;
    assign cmd[i].load  = push_load && (widx == CNT_W'(i));

    tsri_cell #(
      .TIME_BITS (TIME_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd[i]),
      .nb_byte   (nb_byte),
      .nb_stamp  (nb_stamp),
      .in_byte   (byte_r),
      .in_stamp  (push_stamp),
      .clock_now (clock_r),
      .count     (count_r),
      .byte_q    (cell_byte[i]),
      .stamp_q   (cell_stamp[i]),
      .due       (due_vec[i])
    );
  end

  // --------------------------------------------------------------------------
  // due-count scan over the settled row
  // --------------------------------------------------------------------------
  tsri_scan #(
    .DEPTH (INBOX_DEPTH),
    .CNT_W (CNT_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .due_vec  (due_vec),
    .byte_vec (cell_byte),
    .raised   (raised_r),
    .done     (scan_done),
    .due_cnt  (scan_due),
    .pick     (scan_pick)
  );

endmodule
